// File: hw/rtl/tswe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tswe_pkg
// Shared types and constants of the time sliding window expiry block.
// ----------------------------------------------------------------------------
package tswe_pkg;

    localparam int WINDOW_DEPTH = 32;
    localparam int IDX_W        = $clog2(WINDOW_DEPTH);
    localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W        = IDX_W + 1;

    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic ACT_INSERT    = 1'b0;
    localparam logic ACT_HEARTBEAT = 1'b1;

    typedef enum logic [1:0] {
        KIND_PLUS,
        KIND_MINUS,
        KIND_HEARTBEAT,
        KIND_REJECT
    } kind_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_EXPIRE,
        B_INSERT,
        B_HEART,
        B_REJECT,
        B_FLUSH
    } back_state_t;

    // classified element handed from front to back
    typedef struct packed {
        logic        action;
        logic [31:0] event_time;
        logic [31:0] tuple_ref;
        logic        rejected;
        logic        exp_en;
        logic [31:0] limit;
        logic [31:0] win;
    } cmd_t;

    typedef struct packed {
        logic [31:0] ev_time;
        logic [31:0] handle;
    } entry_t;

    typedef struct packed {
        logic [CNT_W-1:0] held_count;
    } back_status_t;

endpackage

// File: hw/rtl/tswe_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tswe_front
// Accepts stream elements, checks time order and precomputes the expiry limit.
// ----------------------------------------------------------------------------
module tswe_front import tswe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic [31:0] event_time,
    input  logic [31:0] tuple_ref,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    output logic        q_push,
    output cmd_t        q_cmd,
    input  logic        q_full
);

    logic [31:0] window_reg;
    logic [31:0] window_next;
    logic [31:0] lit_reg;
    logic [31:0] lit_next;
    logic [31:0] win_eff;
    logic        rejected;

    // zero window behaves as one
    assign win_eff  = (window_reg == '0) ? 32'd1 : window_reg;
    assign rejected = event_time < lit_reg;
    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        q_cmd.action     = action;
        q_cmd.event_time = event_time;
        q_cmd.tuple_ref  = tuple_ref;
        q_cmd.rejected   = rejected;
        q_cmd.exp_en     = event_time >= win_eff;
        q_cmd.limit      = event_time - win_eff;
        q_cmd.win        = win_eff;
    end

    always_comb
    begin
        window_next = cfg_we ? cfg_wdata : window_reg;
        lit_next    = (q_push && !rejected) ? event_time : lit_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= 32'd1;
            lit_reg    <= '0;
        end
        else
        begin
            window_reg <= window_next;
            lit_reg    <= lit_next;
        end
    end

endmodule

// File: hw/rtl/tswe_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tswe_queue
// Short command queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module tswe_queue import tswe_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    input  logic pop,
    output cmd_t pop_data,
    output logic valid
);

    cmd_t              slots [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] fill_reg;
    logic [QCNT_W-1:0] fill_next;
    logic              do_push;
    logic              do_pop;

    assign full     = fill_reg == QCNT_W'(QUEUE_DEPTH);
    assign valid    = fill_reg != '0;
    assign pop_data = slots[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

// File: hw/rtl/tswe_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tswe_back
// Executes commands: expires stored tuples, stores inserts, emits heartbeats and rejects.
// ----------------------------------------------------------------------------
module tswe_back import tswe_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         q_valid,
    input  cmd_t         q_data,
    output logic         q_pop,
    output logic         out_valid,
    input  logic         out_stall,
    output logic [1:0]   kind,
    output logic [31:0]  out_time,
    output logic [31:0]  out_tuple,
    output logic         last,
    output back_status_t status
);

    back_state_t      state_reg;
    back_state_t      state_next;
    cmd_t             cmd_reg;
    cmd_t             cmd_next;
    logic [IDX_W-1:0] oldest_reg;
    logic [IDX_W-1:0] oldest_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [31:0]      lot_reg;
    logic [31:0]      lot_next;

    // one result held back until it is known whether another follows
    logic             pend_valid_reg;
    logic             pend_valid_next;
    kind_t            pend_kind_reg;
    kind_t            pend_kind_next;
    logic [31:0]      pend_time_reg;
    logic [31:0]      pend_time_next;
    logic [31:0]      pend_tuple_reg;
    logic [31:0]      pend_tuple_next;

    logic             out_valid_reg;
    logic             out_valid_next;
    kind_t            out_kind_reg;
    kind_t            out_kind_next;
    logic [31:0]      out_time_reg;
    logic [31:0]      out_time_next;
    logic [31:0]      out_tuple_reg;
    logic [31:0]      out_tuple_next;
    logic             out_last_reg;
    logic             out_last_next;

    entry_t           store_mem [WINDOW_DEPTH];
    entry_t           head_reg;
    entry_t           wr_entry;
    logic             wr_en;
    logic [SUM_W-1:0] tail_sum;
    logic [IDX_W-1:0] tail_idx;

    logic             out_free;
    logic             can_emit;
    logic             expire_now;
    logic             store_full;
    logic             heart_due;
    logic             new_valid;
    kind_t            new_kind;
    logic [31:0]      new_time;
    logic [31:0]      new_tuple;
    logic             load_out;
    logic             load_last;

    assign out_free   = !out_valid_reg || !out_stall;
    assign can_emit   = !pend_valid_reg || out_free;
    assign expire_now = cmd_reg.exp_en && (count_reg != '0)
                        && (head_reg.ev_time <= cmd_reg.limit);
    assign store_full = count_reg == CNT_W'(WINDOW_DEPTH);
    assign heart_due  = lot_reg < cmd_reg.event_time;

    assign tail_sum = SUM_W'(oldest_reg) + SUM_W'(count_reg);
    assign tail_idx = (tail_sum >= SUM_W'(WINDOW_DEPTH))
                      ? IDX_W'(tail_sum - SUM_W'(WINDOW_DEPTH))
                      : IDX_W'(tail_sum);
    assign wr_entry.ev_time = cmd_reg.event_time;
    assign wr_entry.handle  = cmd_reg.tuple_ref;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = q_data.rejected ? B_REJECT : B_EXPIRE;
                end
            end
            B_EXPIRE:
            begin
                if (!expire_now)
                begin
                    state_next = B_INSERT;
                end
            end
            B_INSERT:
            begin
                if (cmd_reg.action == ACT_HEARTBEAT || can_emit)
                begin
                    state_next = B_HEART;
                end
            end
            B_HEART:
            begin
                if (!heart_due || can_emit)
                begin
                    state_next = B_FLUSH;
                end
            end
            B_REJECT:
            begin
                if (can_emit)
                begin
                    state_next = B_FLUSH;
                end
            end
            B_FLUSH:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_pop           = 1'b0;
        cmd_next        = cmd_reg;
        oldest_next     = oldest_reg;
        count_next      = count_reg;
        lot_next        = lot_reg;
        wr_en           = 1'b0;
        new_valid       = 1'b0;
        new_kind        = KIND_PLUS;
        new_time        = cmd_reg.event_time;
        new_tuple       = '0;
        load_out        = 1'b0;
        load_last       = 1'b0;
        pend_valid_next = pend_valid_reg;
        pend_kind_next  = pend_kind_reg;
        pend_time_next  = pend_time_reg;
        pend_tuple_next = pend_tuple_reg;

        case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop    = 1'b1;
                    cmd_next = q_data;
                end
            end
            B_EXPIRE:
            begin
                if (expire_now && can_emit)
                begin
                    new_valid   = 1'b1;
                    new_kind    = KIND_MINUS;
                    new_time    = head_reg.ev_time + cmd_reg.win;
                    new_tuple   = head_reg.handle;
                    lot_next    = new_time;
                    oldest_next = (oldest_reg == IDX_W'(WINDOW_DEPTH - 1))
                                  ? '0 : oldest_reg + 1'b1;
                    count_next  = count_reg - 1'b1;
                end
            end
            B_INSERT:
            begin
                if (cmd_reg.action == ACT_INSERT && can_emit)
                begin
                    new_valid = 1'b1;
                    if (store_full)
                    begin
                        new_kind = KIND_REJECT;
                    end
                    else
                    begin
                        new_kind   = KIND_PLUS;
                        new_tuple  = cmd_reg.tuple_ref;
                        wr_en      = 1'b1;
                        count_next = count_reg + 1'b1;
                        lot_next   = cmd_reg.event_time;
                    end
                end
            end
            B_HEART:
            begin
                if (heart_due && can_emit)
                begin
                    new_valid = 1'b1;
                    new_kind  = KIND_HEARTBEAT;
                    lot_next  = cmd_reg.event_time;
                end
            end
            B_REJECT:
            begin
                if (can_emit)
                begin
                    new_valid = 1'b1;
                    new_kind  = KIND_REJECT;
                end
            end
            B_FLUSH:
            begin
                if (pend_valid_reg && out_free)
                begin
                    load_out        = 1'b1;
                    load_last       = 1'b1;
                    pend_valid_next = 1'b0;
                end
            end
            default:
            begin
            end
        endcase

        // a new result pushes the held one out, which then cannot be last
        if (new_valid)
        begin
            if (pend_valid_reg)
            begin
                load_out = 1'b1;
            end
            pend_valid_next = 1'b1;
            pend_kind_next  = new_kind;
            pend_time_next  = new_time;
            pend_tuple_next = new_tuple;
        end

        out_valid_next = load_out ? 1'b1 : (out_valid_reg && out_stall);
        out_kind_next  = load_out ? pend_kind_reg : out_kind_reg;
        out_time_next  = load_out ? pend_time_reg : out_time_reg;
        out_tuple_next = load_out ? pend_tuple_reg : out_tuple_reg;
        out_last_next  = load_out ? load_last : out_last_reg;
    end

    // store with write-first forwarding so head_reg tracks the oldest slot
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[tail_idx] <= wr_entry;
        end
        if (wr_en && tail_idx == oldest_next)
        begin
            head_reg <= wr_entry;
        end
        else
        begin
            head_reg <= store_mem[oldest_next];
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        pend_kind_reg  <= pend_kind_next;
        pend_time_reg  <= pend_time_next;
        pend_tuple_reg <= pend_tuple_next;
        out_kind_reg   <= out_kind_next;
        out_time_reg   <= out_time_next;
        out_tuple_reg  <= out_tuple_next;
        out_last_reg   <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            oldest_reg     <= '0;
            count_reg      <= '0;
            lot_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            oldest_reg     <= oldest_next;
            count_reg      <= count_next;
            lot_reg        <= lot_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = out_kind_reg;
    assign out_time  = out_time_reg;
    assign out_tuple = out_tuple_reg;
    assign last      = out_last_reg;

    assign status.held_count = count_reg;

endmodule

// File: hw/rtl/time_sliding_window_expiry.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// time_sliding_window_expiry
// Time based sliding window: expires stored tuples and forwards new ones.
// ----------------------------------------------------------------------------
//   channel  | handshake                | payload
//   ---------+--------------------------+-----------------------------------
//   input    | in_valid / in_stall      | action, event_time, tuple_ref
//   output   | out_valid / out_stall    | kind, out_time, out_tuple, last
//   config   | cfg_we (no wait)         | cfg_wdata -> window_size
//
// The back part's expiry loop retires one stored tuple per cycle while the
// output can take results, bound by the single read port of the tuple store.
// A two-entry command queue lets the front take elements while the back works.
// Reset clears control state only; the tuple store is not cleared.
// out_stall holds the output register; the back waits while it is held.
// ----------------------------------------------------------------------------
module time_sliding_window_expiry import tswe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic [31:0] event_time,
    input  logic [31:0] tuple_ref,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [31:0] out_time,
    output logic [31:0] out_tuple,
    output logic        last,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata
);

    logic         q_push;
    logic         q_full;
    logic         q_pop;
    logic         q_valid;
    cmd_t         q_in;
    cmd_t         q_out;
    back_status_t status;

    tswe_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .event_time (event_time),
        .tuple_ref  (tuple_ref),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .q_push     (q_push),
        .q_cmd      (q_in),
        .q_full     (q_full)
    );

    tswe_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .valid     (q_valid)
    );

    tswe_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (q_out),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .out_time  (out_time),
        .out_tuple (out_tuple),
        .last      (last),
        .status    (status)
    );

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push && q_full))
        else $error("command pushed into a full queue");

    a_pop_needs_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_pop && !q_valid))
        else $error("back took a command from an empty queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        status.held_count <= CNT_W'(WINDOW_DEPTH))
        else $error("tuple store over capacity");

    a_no_tuple_on_hb: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_HEARTBEAT || kind == KIND_REJECT) |-> out_tuple == '0)
        else $error("heartbeat or reject result carries a tuple");

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the time sliding window expiry block.
// A transaction-level copy of the window store predicts every minus, plus,
// heartbeat and reject result. Each input transfer adds its expected results
// to a queue. Output transfers are checked in order against that queue.
// The run has a short directed part, random phases, then wide-window cases.
// Each phase uses its own window length and one of four mixes of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;
    import tswe_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 64;
    localparam int PHASE_ITEMS    = 50;
    localparam int NUM_PHASES     = 8;
    localparam logic [31:0] PHASE_WINDOWS [NUM_PHASES] =
        '{32'd1, 32'd3, 32'd16, 32'd200, 32'd100000, 32'd7, 32'd64, 32'd2};

    typedef struct {
        kind_t       kind;
        logic [31:0] stamp;
        logic [31:0] handle;
        logic        last;
    } window_result_t;

    class window_scoreboard;
        logic [31:0]    window_len;
        logic [31:0]    slot_handle [WINDOW_DEPTH];
        logic [31:0]    slot_time [WINDOW_DEPTH];
        int unsigned    head_slot;
        int unsigned    live_count;
        logic [31:0]    input_horizon;
        logic [31:0]    output_horizon;
        window_result_t batch [$];
        window_result_t due_results [$];
        int unsigned    mismatches;

        function new();
            window_len     = 32'd1;
            head_slot      = 0;
            live_count     = 0;
            input_horizon  = 32'd0;
            output_horizon = 32'd0;
            mismatches     = 0;
        endfunction

        function void set_window(logic [31:0] value);
            window_len = value;
        endfunction

        function int unsigned pending();
            return due_results.size();
        endfunction

        function void emit(kind_t k, logic [31:0] stamp, logic [31:0] handle);
            window_result_t r;
            r.kind   = k;
            r.stamp  = stamp;
            r.handle = handle;
            r.last   = 1'b0;
            batch.push_back(r);
        endfunction

        // expirations first, then the insert, then a heartbeat if output time lags
        function void advance_window(logic act, logic [31:0] t, logic [31:0] handle);
            logic [31:0]    w;
            int unsigned    tail;
            window_result_t r;
            batch.delete();
            w = (window_len == 32'd0) ? 32'd1 : window_len;
            if (t < input_horizon)
            begin
                emit(KIND_REJECT, t, 32'd0);
            end
            else
            begin
                input_horizon = t;
                if (t >= w)
                begin
                    while (live_count != 0 && slot_time[head_slot] <= t - w)
                    begin
                        emit(KIND_MINUS, slot_time[head_slot] + w, slot_handle[head_slot]);
                        output_horizon = slot_time[head_slot] + w;
                        head_slot      = (head_slot + 1) % WINDOW_DEPTH;
                        live_count--;
                    end
                end
                if (act == ACT_INSERT)
                begin
                    if (live_count >= WINDOW_DEPTH)
                    begin
                        emit(KIND_REJECT, t, 32'd0);
                    end
                    else
                    begin
                        tail              = (head_slot + live_count) % WINDOW_DEPTH;
                        slot_handle[tail] = handle;
                        slot_time[tail]   = t;
                        live_count++;
                        emit(KIND_PLUS, t, handle);
                        output_horizon = t;
                    end
                end
                if (output_horizon < input_horizon)
                begin
                    emit(KIND_HEARTBEAT, input_horizon, 32'd0);
                    output_horizon = input_horizon;
                end
            end
            foreach (batch[i])
            begin
                r      = batch[i];
                r.last = (i == batch.size() - 1);
                due_results.push_back(r);
            end
        endfunction

        function void check_result(kind_t k, logic [31:0] stamp, logic [31:0] handle,
                                   logic last);
            window_result_t e;
            if (due_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: kind %0d time %h tuple %h last %b",
                             k, stamp, handle, last);
                return;
            end
            e = due_results.pop_front();
            if (k !== e.kind || stamp !== e.stamp || handle !== e.handle || last !== e.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"result mismatch: expected kind %0d time %h tuple %h last %b,",
                              " got kind %0d time %h tuple %h last %b"},
                             e.kind, e.stamp, e.handle, e.last, k, stamp, handle, last);
            end
        endfunction
    endclass

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_stall;
    logic        action     = 1'b0;
    logic [31:0] event_time = 32'd0;
    logic [31:0] tuple_ref  = 32'd0;
    logic        out_valid;
    logic        out_stall  = 1'b0;
    logic [1:0]  kind;
    logic [31:0] out_time;
    logic [31:0] out_tuple;
    logic        last;
    logic        cfg_we     = 1'b0;
    logic [31:0] cfg_wdata  = 32'd0;

    window_scoreboard board;
    int unsigned      send_gap_pct = 0;
    int unsigned      stall_pct    = 0;
    int unsigned      idle_cycles  = 0;
    logic [31:0]      now_t        = 32'd0;

    time_sliding_window_expiry dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .event_time (event_time),
        .tuple_ref  (tuple_ref),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kind       (kind),
        .out_time   (out_time),
        .out_tuple  (out_tuple),
        .last       (last),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_result(kind_t'(kind), out_time, out_tuple, last);
    end

    // ends the run when no transfer happens on either channel for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles == WATCHDOG_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    task automatic set_idling(input int mode);
        case (mode)
            0:
            begin
                send_gap_pct = 0;
                stall_pct    = 0;
            end
            1:
            begin
                send_gap_pct = 50;
                stall_pct    = 0;
            end
            2:
            begin
                send_gap_pct = 0;
                stall_pct    = 50;
            end
            default:
            begin
                send_gap_pct = 24;
                stall_pct    = 24;
            end
        endcase
    endtask

    // valid stays high between back-to-back transfers
    task automatic send_element(input logic act, input logic [31:0] t,
                                input logic [31:0] handle);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        action     <= act;
        event_time <= t;
        tuple_ref  <= handle;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        board.advance_window(act, t, handle);
        if (t > now_t)
            now_t = t;
    endtask

    // heartbeats with nothing to report leave the block busy after the last result
    task automatic settle();
        in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_window(input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        board.set_window(value);
        @(posedge clk);
    endtask

    task automatic run_phase(input logic [31:0] win, input int mode);
        int unsigned sent;
        int unsigned burst;
        int unsigned pick;
        logic [31:0] w;
        settle();
        write_window(win);
        set_idling(mode);
        w    = (win == 32'd0) ? 32'd1 : win;
        sent = 0;
        while (sent < PHASE_ITEMS)
        begin
            pick = $urandom_range(99);
            if (pick < 8 && now_t != 0)
            begin
                // late timestamp
                send_element(1'($urandom_range(1)), $urandom_range(now_t - 1), $urandom);
                sent++;
            end
            else if (pick < 12)
            begin
                // fill the store at one time, then expire everything at once
                burst = $urandom_range(30, 34);
                repeat (burst) send_element(ACT_INSERT, now_t, $urandom);
                send_element(ACT_HEARTBEAT, now_t + w + $urandom_range(3), $urandom);
                sent += burst + 1;
            end
            else
            begin
                send_element(($urandom_range(3) == 0) ? ACT_HEARTBEAT : ACT_INSERT,
                             now_t + (($urandom_range(9) == 0) ? 3 * w : $urandom_range(w)),
                             $urandom);
                sent++;
            end
        end
    endtask

    initial
    begin
        board = new();
        set_idling(0);
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // window left at its reset length
        send_element(ACT_INSERT, 32'd0, 32'd0);
        send_element(ACT_INSERT, 32'd0, 32'hFFFF_FFFF);
        send_element(ACT_HEARTBEAT, 32'd0, 32'd0);
        send_element(ACT_HEARTBEAT, 32'd1, 32'hFFFF_FFFF);
        send_element(ACT_INSERT, 32'd3, 32'hA5A5_A5A5);
        send_element(ACT_HEARTBEAT, 32'd10, 32'd0);
        send_element(ACT_INSERT, 32'd5, 32'h1234_5678);
        send_element(ACT_HEARTBEAT, 32'd2, 32'd0);

        // zero window behaves as one
        settle();
        write_window(32'd0);
        send_element(ACT_INSERT, 32'd10, 32'h5A5A_5A5A);
        send_element(ACT_HEARTBEAT, 32'd11, 32'd0);

        settle();
        write_window(32'd20);
        send_element(ACT_INSERT, 32'd12, 32'h0000_0001);
        send_element(ACT_INSERT, 32'd13, 32'h8000_0000);
        send_element(ACT_HEARTBEAT, 32'd40, 32'd0);

        for (int p = 0; p < NUM_PHASES; p++)
            run_phase(PHASE_WINDOWS[p], p % 4);

        // very wide windows near the top of the time range
        settle();
        write_window(32'h8000_0000);
        set_idling(3);
        send_element(ACT_INSERT, now_t + 32'd1, 32'hFFFF_FFFF);
        send_element(ACT_HEARTBEAT, now_t + 32'h8000_0000, 32'd0);
        settle();
        write_window(32'hFFFF_FFFF);
        send_element(ACT_INSERT, 32'hFFFF_FFFE, $urandom);
        send_element(ACT_INSERT, 32'hFFFF_FFFF, 32'd0);
        send_element(ACT_HEARTBEAT, 32'hFFFF_FFFF, $urandom);
        send_element(ACT_INSERT, 32'd0, $urandom);
        settle();

        if (board.mismatches == 0 && board.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
